// ===== rtl/trisa_pkg.sv =====
package trisa_pkg;

    localparam int FIELD_W      = 32;
    localparam int CFG_W        = 32;
    localparam int OUT_W        = 48;
    localparam int VEC_BITS     = 19;
    localparam int V_W          = VEC_BITS + 1;
    localparam int SQ_W         = 2 * VEC_BITS + 2;
    localparam int RT_W         = SQ_W / 2;
    localparam int A_W          = 41;
    localparam int B_W          = RT_W + 1;
    localparam int P_W          = A_W + B_W;
    localparam int XY_W         = 64;
    localparam int CORDIC_BITS  = 40;
    localparam int CX_W         = CORDIC_BITS + 4;
    localparam int ZW           = 34;
    localparam int TERM_W       = ZW + 1;
    localparam int BL_W         = 7;
    localparam int OP_W         = 5;
    localparam int CORDIC_STEPS = 32;
    localparam int STEP_W       = 5;

    localparam logic [1:0] CFG_QUERY_X = 2'd0;
    localparam logic [1:0] CFG_QUERY_Y = 2'd1;
    localparam logic [1:0] CFG_QUERY_Z = 2'd2;

    localparam logic [OP_W-1:0] OP_LAST_Y  = 5'd17;
    localparam logic [OP_W-1:0] OP_FIRST_X = 5'd18;
    localparam logic [OP_W-1:0] OP_LAST    = 5'd31;

    localparam logic signed [ZW-1:0] QTR_TURN = ZW'(64'sd1073741824);

    typedef enum logic [3:0] {
        SRC_V0, SRC_V1, SRC_V2, SRC_V3, SRC_V4, SRC_V5, SRC_V6, SRC_V7, SRC_V8,
        SRC_T, SRC_LA, SRC_LB, SRC_LC
    } t_src;

    typedef enum logic [2:0] {DST_SA, DST_SB, DST_SC, DST_T, DST_Y, DST_X} t_dst;

    typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} t_accop;

    typedef struct packed {
        t_src   a;
        t_src   b;
        t_dst   dst;
        t_accop mode;
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_NORM, S_MUL, S_SQRT_GO, S_SQRT_WAIT, S_ATAN_GO, S_ATAN_WAIT, S_ACC
    } t_state;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_STEP, C_ROUND} t_cst;

    // multiply-accumulate program: sums of squares, triple product, denominator
    function automatic t_op op_of(input logic [OP_W-1:0] k);
        t_op o;
        unique case (k)
            5'd0:  o = '{SRC_V0, SRC_V0, DST_SA, ACC_LOAD};
            5'd1:  o = '{SRC_V1, SRC_V1, DST_SA, ACC_ADD};
            5'd2:  o = '{SRC_V2, SRC_V2, DST_SA, ACC_ADD};
            5'd3:  o = '{SRC_V3, SRC_V3, DST_SB, ACC_LOAD};
            5'd4:  o = '{SRC_V4, SRC_V4, DST_SB, ACC_ADD};
            5'd5:  o = '{SRC_V5, SRC_V5, DST_SB, ACC_ADD};
            5'd6:  o = '{SRC_V6, SRC_V6, DST_SC, ACC_LOAD};
            5'd7:  o = '{SRC_V7, SRC_V7, DST_SC, ACC_ADD};
            5'd8:  o = '{SRC_V8, SRC_V8, DST_SC, ACC_ADD};
            5'd9:  o = '{SRC_V4, SRC_V8, DST_T,  ACC_LOAD};
            5'd10: o = '{SRC_V5, SRC_V7, DST_T,  ACC_SUB};
            5'd11: o = '{SRC_T,  SRC_V0, DST_Y,  ACC_LOAD};
            5'd12: o = '{SRC_V3, SRC_V8, DST_T,  ACC_LOAD};
            5'd13: o = '{SRC_V5, SRC_V6, DST_T,  ACC_SUB};
            5'd14: o = '{SRC_T,  SRC_V1, DST_Y,  ACC_SUB};
            5'd15: o = '{SRC_V3, SRC_V7, DST_T,  ACC_LOAD};
            5'd16: o = '{SRC_V4, SRC_V6, DST_T,  ACC_SUB};
            5'd17: o = '{SRC_T,  SRC_V2, DST_Y,  ACC_ADD};
            5'd18: o = '{SRC_LA, SRC_LB, DST_T,  ACC_LOAD};
            5'd19: o = '{SRC_T,  SRC_LC, DST_X,  ACC_LOAD};
            5'd20: o = '{SRC_V0, SRC_V3, DST_T,  ACC_LOAD};
            5'd21: o = '{SRC_V1, SRC_V4, DST_T,  ACC_ADD};
            5'd22: o = '{SRC_V2, SRC_V5, DST_T,  ACC_ADD};
            5'd23: o = '{SRC_T,  SRC_LC, DST_X,  ACC_ADD};
            5'd24: o = '{SRC_V3, SRC_V6, DST_T,  ACC_LOAD};
            5'd25: o = '{SRC_V4, SRC_V7, DST_T,  ACC_ADD};
            5'd26: o = '{SRC_V5, SRC_V8, DST_T,  ACC_ADD};
            5'd27: o = '{SRC_T,  SRC_LA, DST_X,  ACC_ADD};
            5'd28: o = '{SRC_V6, SRC_V0, DST_T,  ACC_LOAD};
            5'd29: o = '{SRC_V7, SRC_V1, DST_T,  ACC_ADD};
            5'd30: o = '{SRC_V8, SRC_V2, DST_T,  ACC_ADD};
            5'd31: o = '{SRC_T,  SRC_LB, DST_X,  ACC_ADD};
        endcase
        return o;
    endfunction

    // atan(2^-i) in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;
            5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            5'd31: t = 32'h00000000;
        endcase
        return t;
    endfunction

    function automatic logic [BL_W-1:0] bitlen64(input logic [XY_W-1:0] v);
        logic [BL_W-1:0] n;
        n = '0;
        for (int i = 0; i < XY_W; i++) begin
            if (v[i]) n = BL_W'(i + 1);
        end
        return n;
    endfunction

endpackage

// ===== rtl/trisa_isqrt.sv =====
module trisa_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [trisa_pkg::SQ_W-1:0]    i_value,
    output logic                          o_done,
    output logic [trisa_pkg::RT_W-1:0]    o_root
);
    import trisa_pkg::*;

    localparam int REM_W = RT_W + 2;
    localparam int CNT_W = $clog2(RT_W);

    logic [SQ_W-1:0]  r_src;
    logic [REM_W-1:0] r_rem;
    logic [RT_W-1:0]  r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W+1:0] rem_next;
    logic [REM_W+1:0] trial;
    logic             fits;

    // two radicand bits per cycle
    always_comb begin
        rem_next = {r_rem, r_src[SQ_W-1 -: 2]};
        trial    = (REM_W+2)'({r_root, 2'b01});
        fits     = rem_next >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(RT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_src <= {r_src[SQ_W-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (fits) begin
                r_rem  <= REM_W'(rem_next - trial);
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_next);
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/trisa_cordic.sv =====
module trisa_cordic #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [trisa_pkg::XY_W-1:0]   i_x,
    input  logic signed [trisa_pkg::XY_W-1:0]   i_y,
    output logic                                o_done,
    output logic signed [trisa_pkg::TERM_W-1:0] o_term
);
    import trisa_pkg::*;

    localparam int RS = 32 - ANGLE_FRAC_BITS;
    localparam logic [ZW:0] HALF = (RS > 0) ? ((ZW+1)'(1) << (RS - 1)) : '0;

    t_cst r_st, n_st;

    logic [XY_W-1:0]        r_mx, r_my;
    logic                   r_nx, r_ny;
    logic signed [CX_W-1:0] r_x, r_y;
    logic signed [ZW-1:0]   r_z;
    logic [STEP_W-1:0]      r_i;
    logic                   r_done;
    logic signed [TERM_W-1:0] r_term;

    logic [BL_W-1:0]        bl;
    logic signed [CX_W-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0]   at;
    logic [ZW-1:0]          mz;
    logic [ZW:0]            rnd;
    logic signed [TERM_W-1:0] tmag;

    always_comb begin
        bl   = bitlen64(r_mx | r_my);
        xs   = $signed(CX_W'(r_mx[CORDIC_BITS-1:0]));
        ys   = $signed(CX_W'(r_my[CORDIC_BITS-1:0]));
        if (r_nx) xs = -xs;
        if (r_ny) ys = -ys;
        dx   = r_y >>> r_i;
        dy   = r_x >>> r_i;
        at   = $signed(ZW'(atan_turn(r_i)));
        mz   = r_z[ZW-1] ? ZW'(-r_z) : ZW'(r_z);
        rnd  = ({1'b0, mz} + HALF) >> RS;
        tmag = $signed(TERM_W'(rnd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= C_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            C_IDLE:  if (i_start) n_st = C_NORM;
            C_NORM: begin
                if (bl == '0) n_st = C_ROUND;
                else if (bl == BL_W'(CORDIC_BITS)) n_st = C_STEP;
            end
            C_STEP:  if (r_i == STEP_W'(CORDIC_STEPS - 1)) n_st = C_ROUND;
            C_ROUND: n_st = C_IDLE;
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= (r_st == C_ROUND);
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            C_IDLE: begin
                r_nx <= i_x[XY_W-1];
                r_ny <= i_y[XY_W-1];
                r_mx <= i_x[XY_W-1] ? XY_W'(-i_x) : XY_W'(i_x);
                r_my <= i_y[XY_W-1] ? XY_W'(-i_y) : XY_W'(i_y);
            end
            C_NORM: begin
                if (bl == '0) begin
                    r_z <= '0;
                end else if (bl >= BL_W'(CORDIC_BITS + 4)) begin
                    r_mx <= r_mx >> 4;
                    r_my <= r_my >> 4;
                end else if (bl > BL_W'(CORDIC_BITS)) begin
                    r_mx <= r_mx >> 1;
                    r_my <= r_my >> 1;
                end else if (bl <= BL_W'(CORDIC_BITS - 4)) begin
                    r_mx <= r_mx << 4;
                    r_my <= r_my << 4;
                end else if (bl < BL_W'(CORDIC_BITS)) begin
                    r_mx <= r_mx << 1;
                    r_my <= r_my << 1;
                end else begin
                    r_i <= '0;
                    if (xs < 0) begin
                        if (ys >= 0) begin
                            r_x <= ys;
                            r_y <= -xs;
                            r_z <= QTR_TURN;
                        end else begin
                            r_x <= -ys;
                            r_y <= xs;
                            r_z <= -QTR_TURN;
                        end
                    end else begin
                        r_x <= xs;
                        r_y <= ys;
                        r_z <= '0;
                    end
                end
            end
            C_STEP: begin
                r_i <= r_i + 1'b1;
                if (!r_y[CX_W-1]) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end
            end
            C_ROUND: r_term <= r_z[ZW-1] ? -tmag : tmag;
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_term = r_term;

endmodule

// ===== rtl/triangle_solid_angle_winding_sum_core.sv =====
// Winding-number accumulator over a stream of triangles about a query point.
// Configuration: write the query point (x, y, z index 0..2) with i_cfg_we
// while the block is idle; writes to other indexes are dropped.
// Input channel: one beat per triangle (three vertices, signed Q16.16) on
// i_in_valid / o_in_stall. A beat with i_last_triangle set closes the set.
// Output channel: o_out_valid / i_out_stall carries one beat per set, the
// summed winding in 2^-ANGLE_FRAC_BITS turns plus a saturation flag.
// Each triangle occupies the datapath from beat to beat: one-bit-per-cycle
// vector scaling, 32 operations on the single shared multiplier, the three
// parallel bit-pair square roots, scaling for atan2, 32 CORDIC iterations
// with start and rounding for atan2, and the accumulate step.
// A triangle whose vertices all sit on the query point goes from the
// vector scaling straight to the accumulate step.
// o_in_stall is high from acceptance until the term is accumulated; the next
// triangle is taken the cycle after.
// The result register parts the two channels: a later triangle is worked on
// while a result waits; only a closing triangle waits for the register to
// empty when the receiver stalls.
// Reset clears the query point, the sum and the clip flag, and empties the
// output register.
module triangle_solid_angle_winding_sum_core #(
    parameter int COORD_WIDTH     = 32,
    parameter int ACC_WIDTH       = 48,
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [trisa_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_a_x,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_a_y,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_a_z,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_b_x,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_b_y,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_b_z,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_c_x,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_c_y,
    input  logic signed [trisa_pkg::FIELD_W-1:0]  i_c_z,
    input  logic                                  i_last_triangle,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [trisa_pkg::OUT_W-1:0]    o_winding_number,
    output logic                                  o_saturated
);
    import trisa_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int MW    = (CW > VEC_BITS) ? CW : VEC_BITS;
    localparam int SUM_W = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;

    t_state r_state, n_state;

    logic signed [CW-1:0]        r_qx, r_qy, r_qz;
    logic [MW-1:0]               r_mag [9];
    logic                        r_neg [9];
    logic                        r_last;
    logic [OP_W-1:0]             r_op;
    logic                        r_phase;
    logic signed [P_W-1:0]       r_prod;
    logic [SQ_W-1:0]             r_sa, r_sb, r_sc;
    logic signed [A_W-1:0]       r_t;
    logic signed [XY_W-1:0]      r_y, r_x;
    logic signed [TERM_W-1:0]    r_term;
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic                        r_clip;
    logic                        r_out_valid;
    logic signed [OUT_W-1:0]     r_out_wn;
    logic                        r_out_sat;

    logic                        in_acc;
    logic                        out_free;
    logic signed [CW-1:0]        in_c [9];
    logic signed [CW-1:0]        q_c  [9];
    logic signed [CW:0]          d    [9];
    logic [MW-1:0]               or_all;
    logic [BL_W-1:0]             bl;
    logic signed [V_W-1:0]       mv   [9];
    logic signed [V_W-1:0]       v    [9];
    t_op                         op;
    logic signed [A_W-1:0]       a_op;
    logic signed [B_W-1:0]       b_op;
    logic signed [XY_W-1:0]      base, p64, res;
    logic                        sq_start, sq_done_a, sq_done_b, sq_done_c;
    logic [RT_W-1:0]             la, lb, lc;
    logic                        cd_start, cd_done;
    logic signed [TERM_W-1:0]    cd_term;
    logic signed [SUM_W-1:0]     sum;
    logic                        ovf;
    logic signed [ACC_WIDTH-1:0] acc_next;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        in_c[0] = $signed(CW'($unsigned(i_a_x)));
        in_c[1] = $signed(CW'($unsigned(i_a_y)));
        in_c[2] = $signed(CW'($unsigned(i_a_z)));
        in_c[3] = $signed(CW'($unsigned(i_b_x)));
        in_c[4] = $signed(CW'($unsigned(i_b_y)));
        in_c[5] = $signed(CW'($unsigned(i_b_z)));
        in_c[6] = $signed(CW'($unsigned(i_c_x)));
        in_c[7] = $signed(CW'($unsigned(i_c_y)));
        in_c[8] = $signed(CW'($unsigned(i_c_z)));
        for (int k = 0; k < 9; k++) begin
            q_c[k] = (k % 3 == 0) ? r_qx : (k % 3 == 1) ? r_qy : r_qz;
            d[k]   = (CW+1)'(in_c[k]) - (CW+1)'(q_c[k]);
        end
    end

    always_comb begin
        or_all = '0;
        for (int k = 0; k < 9; k++) begin
            or_all = or_all | r_mag[k];
            mv[k]  = $signed({1'b0, r_mag[k][VEC_BITS-1:0]});
            v[k]   = r_neg[k] ? -mv[k] : mv[k];
        end
        bl = bitlen64(XY_W'(or_all));
    end

    // shared multiplier operand selection
    always_comb begin
        op = op_of(r_op);
        unique case (op.a)
            SRC_T:   a_op = r_t;
            SRC_LA:  a_op = A_W'($signed({1'b0, la}));
            SRC_LB:  a_op = A_W'($signed({1'b0, lb}));
            SRC_LC:  a_op = A_W'($signed({1'b0, lc}));
            default: a_op = A_W'(v[4'(op.a)]);
        endcase
        unique case (op.b)
            SRC_T:   b_op = '0;
            SRC_LA:  b_op = $signed({1'b0, la});
            SRC_LB:  b_op = $signed({1'b0, lb});
            SRC_LC:  b_op = $signed({1'b0, lc});
            default: b_op = B_W'(v[4'(op.b)]);
        endcase
        unique case (op.dst)
            DST_SA:  base = $signed(XY_W'(r_sa));
            DST_SB:  base = $signed(XY_W'(r_sb));
            DST_SC:  base = $signed(XY_W'(r_sc));
            DST_T:   base = XY_W'(r_t);
            DST_Y:   base = r_y;
            DST_X:   base = r_x;
            default: base = '0;
        endcase
        p64 = XY_W'(r_prod);
        unique case (op.mode)
            ACC_LOAD: res = p64;
            ACC_ADD:  res = base + p64;
            ACC_SUB:  res = base - p64;
            default:  res = p64;
        endcase
    end

    always_comb begin
        sum      = SUM_W'(r_acc) + SUM_W'(r_term);
        ovf      = (sum[SUM_W-1:ACC_WIDTH-1] != '0) && (sum[SUM_W-1:ACC_WIDTH-1] != '1);
        acc_next = ACC_WIDTH'(sum);
        if (ovf) begin
            acc_next = sum[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                    : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
    end

    assign sq_start = (r_state == S_SQRT_GO);
    assign cd_start = (r_state == S_ATAN_GO);

    trisa_isqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_sa),
        .o_done  (sq_done_a),
        .o_root  (la)
    );

    trisa_isqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_sb),
        .o_done  (sq_done_b),
        .o_root  (lb)
    );

    trisa_isqrt u_sqrt_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_sc),
        .o_done  (sq_done_c),
        .o_root  (lc)
    );

    trisa_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_done  (cd_done),
        .o_term  (cd_term)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_NORM;
            S_NORM: begin
                if (bl == '0) n_state = S_ACC;
                else if (bl == BL_W'(VEC_BITS)) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_phase && r_op == OP_LAST_Y) n_state = S_SQRT_GO;
                else if (r_phase && r_op == OP_LAST) n_state = S_ATAN_GO;
            end
            S_SQRT_GO:   n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: if (sq_done_a) n_state = S_MUL;
            S_ATAN_GO:   n_state = S_ATAN_WAIT;
            S_ATAN_WAIT: if (cd_done) n_state = S_ACC;
            S_ACC:       if (!r_last || out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUERY_X: r_qx <= $signed(CW'(i_cfg_data));
                CFG_QUERY_Y: r_qy <= $signed(CW'(i_cfg_data));
                CFG_QUERY_Z: r_qz <= $signed(CW'(i_cfg_data));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_last <= i_last_triangle;
                for (int k = 0; k < 9; k++) begin
                    r_neg[k] <= d[k][CW];
                    r_mag[k] <= MW'(d[k][CW] ? CW'(-d[k]) : CW'(d[k]));
                end
            end
            S_NORM: begin
                r_op    <= '0;
                r_phase <= 1'b0;
                if (bl == '0) begin
                    r_term <= '0;
                end else if (bl > BL_W'(VEC_BITS)) begin
                    for (int k = 0; k < 9; k++) r_mag[k] <= r_mag[k] >> 1;
                end else if (bl < BL_W'(VEC_BITS)) begin
                    for (int k = 0; k < 9; k++) r_mag[k] <= r_mag[k] << 1;
                end
            end
            S_MUL: begin
                r_phase <= !r_phase;
                if (!r_phase) begin
                    r_prod <= a_op * b_op;
                end else begin
                    r_op <= r_op + 1'b1;
                    unique case (op.dst)
                        DST_SA:  r_sa <= SQ_W'(res);
                        DST_SB:  r_sb <= SQ_W'(res);
                        DST_SC:  r_sc <= SQ_W'(res);
                        DST_T:   r_t  <= A_W'(res);
                        DST_Y:   r_y  <= res;
                        DST_X:   r_x  <= res;
                        default: ;
                    endcase
                end
            end
            S_SQRT_WAIT: r_op <= OP_FIRST_X;
            S_ATAN_WAIT: if (cd_done) r_term <= cd_term;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (r_state == S_ACC) begin
                if (!r_last) begin
                    r_acc  <= acc_next;
                    r_clip <= r_clip | ovf;
                end else if (out_free) begin
                    r_acc       <= '0;
                    r_clip      <= 1'b0;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC && r_last && out_free) begin
            r_out_wn  <= OUT_W'(acc_next);
            r_out_sat <= r_clip | ovf;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_winding_number = r_out_wn;
    assign o_saturated      = r_out_sat;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while a triangle is in flight");

    a_sqrt_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_done_a || sq_done_b || sq_done_c) |-> (r_state == S_SQRT_WAIT))
        else $error("square root finished outside its wait state");

    a_sqrt_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done_a |-> (sq_done_b && sq_done_c))
        else $error("square root units out of step");

    a_atan_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cd_done |-> (r_state == S_ATAN_WAIT))
        else $error("atan2 finished outside its wait state");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import trisa_pkg::*;

    localparam int  SETTLE_CYCLES = 200;
    localparam int  CYCLE_LIMIT   = 2000000;
    localparam int  NUM_PHASES    = 6;
    localparam int  RANDOM_ITEMS  = 1530;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [8:0][FIELD_W-1:0] v;
        logic                    last;
    } t_facet;

    typedef struct packed {
        logic [OUT_W-1:0] winding;
        logic             clipped;
    } t_winding;

    class winding_scoreboard;
        longint   qx, qy, qz;
        longint   acc;
        bit       clip;
        t_winding pending_q[$];
        int       errors;
        int       sets_seen;
        int       facets_seen;

        function new();
            qx = 0; qy = 0; qz = 0; acc = 0; clip = 0;
            errors = 0; sets_seen = 0; facets_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
            longint s;
            s = longint'(signed'(data));
            case (idx)
                CFG_QUERY_X: qx = s;
                CFG_QUERY_Y: qy = s;
                CFG_QUERY_Z: qz = s;
                default: ;
            endcase
        endfunction

        function int bit_length(logic [63:0] v);
            int n;
            n = 0;
            while (v != 0) begin
                v = v >> 1;
                n++;
            end
            return n;
        endfunction

        function logic [63:0] magnitude(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint scale_mag(longint v, int sh);
            logic [63:0] m;
            m = magnitude(v);
            if (sh >= 0) m = m >> sh;
            else m = m << (-sh);
            return v < 0 ? -longint'(m) : longint'(m);
        endfunction

        function longint int_sqrt(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'h1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        function longint vector_atan2(longint y, longint x);
            logic [63:0] mx, my;
            longint z, t, dx, dy;
            int sh;
            mx = magnitude(x);
            my = magnitude(y);
            z = 0;
            if (mx == 0 && my == 0) return 0;
            sh = bit_length(mx > my ? mx : my) - CORDIC_BITS;
            x = scale_mag(x, sh);
            y = scale_mag(y, sh);
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = 64'sd1 << 30;
                end else begin
                    x = -y; y = t; z = -(64'sd1 << 30);
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(atan_turn(STEP_W'(i)));
                end else begin
                    x -= dx; y += dy; z -= longint'(atan_turn(STEP_W'(i)));
                end
            end
            return z;
        endfunction

        function longint solid_angle(longint d[9]);
            logic [63:0] m;
            longint v[9];
            longint la, lb, lc, y, x, z;
            int sh;
            m = 0;
            for (int i = 0; i < 9; i++)
                if (magnitude(d[i]) > m) m = magnitude(d[i]);
            if (m == 0) return 0;
            sh = bit_length(m) - VEC_BITS;
            for (int i = 0; i < 9; i++) v[i] = scale_mag(d[i], sh);
            la = int_sqrt(64'(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]));
            lb = int_sqrt(64'(v[3]*v[3] + v[4]*v[4] + v[5]*v[5]));
            lc = int_sqrt(64'(v[6]*v[6] + v[7]*v[7] + v[8]*v[8]));
            y = v[0] * (v[4]*v[8] - v[5]*v[7])
              - v[1] * (v[3]*v[8] - v[5]*v[6])
              + v[2] * (v[3]*v[7] - v[4]*v[6]);
            x = la * lb * lc
              + (v[0]*v[3] + v[1]*v[4] + v[2]*v[5]) * lc
              + (v[3]*v[6] + v[4]*v[7] + v[5]*v[8]) * la
              + (v[6]*v[0] + v[7]*v[1] + v[8]*v[2]) * lb;
            z = vector_atan2(y, x);
            m = (magnitude(z) + 64'd128) >> 8;
            return z < 0 ? -longint'(m) : longint'(m);
        endfunction

        function void note_facet(t_facet f);
            longint d[9];
            longint q, term, amax, amin;
            t_winding w;
            amax = (64'sd1 <<< 47) - 1;
            amin = -amax - 1;
            for (int i = 0; i < 9; i++) begin
                q = (i % 3 == 0) ? qx : (i % 3 == 1) ? qy : qz;
                d[i] = longint'(signed'(f.v[i])) - q;
            end
            term = solid_angle(d);
            if (term > 0 && acc > amax - term) begin
                acc = amax; clip = 1;
            end else if (term < 0 && acc < amin - term) begin
                acc = amin; clip = 1;
            end else begin
                acc += term;
            end
            facets_seen++;
            if (f.last) begin
                w = '{acc[OUT_W-1:0], clip};
                pending_q = {pending_q, w};
                acc = 0;
                clip = 0;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] wn, logic sat);
            t_winding e;
            sets_seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected result beat winding_number %0d", signed'(wn));
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (wn !== e.winding) begin
                $error("winding_number exp %0d got %0d", signed'(e.winding), signed'(wn));
                errors++;
            end
            if (sat !== e.clipped) begin
                $error("saturated exp %0d got %0d", e.clipped, sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    logic signed [FIELD_W-1:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z;
    logic i_last_triangle;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [OUT_W-1:0] o_winding_number;
    logic o_saturated;

    winding_scoreboard sb;
    int  cycles = 0;
    bit  no_gaps;
    logic [CFG_W-1:0] cur_q[3];

    triangle_solid_angle_winding_sum_core u_dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function int pick_gap();
        if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
        return no_gaps ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_facet(t_facet f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        {i_c_z, i_c_y, i_c_x, i_b_z, i_b_y, i_b_x, i_a_z, i_a_y, i_a_x} <= f.v;
        i_last_triangle <= f.last;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_facet(f);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_query(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y, logic [CFG_W-1:0] z);
        wait_idle();
        write_reg(CFG_QUERY_X, x);
        write_reg(CFG_QUERY_Y, y);
        write_reg(CFG_QUERY_Z, z);
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
        cur_q[0] = x; cur_q[1] = y; cur_q[2] = z;
    endtask

    function logic [FIELD_W-1:0] rand_coord(int axis);
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: return FIELD_W'($signed($urandom_range(0, 2047)) - 1024);
            3: return cur_q[axis] + FIELD_W'($signed($urandom_range(0, 63)) - 32);
            default: return FIELD_W'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    function t_facet rand_facet(bit last);
        t_facet f;
        bit at_query;
        at_query = ($urandom_range(0, 40) == 0);
        for (int i = 0; i < 9; i++)
            f.v[i] = at_query ? cur_q[i % 3] : rand_coord(i % 3);
        f.last = last;
        return f;
    endfunction

    task automatic run_sets(int count);
        int left, n;
        left = count;
        while (left > 0) begin
            n = $urandom_range(1, 8);
            if (n > left) n = left;
            for (int k = 0; k < n; k++) begin
                send_facet(rand_facet(k == n - 1));
                left--;
            end
        end
    endtask

    function t_facet mk(int ax, int ay, int az, int bx, int by, int bz,
                        int cx, int cy, int cz, bit last);
        t_facet f;
        f.v = {cz, cy, cx, bz, by, bx, az, ay, ax};
        f.last = last;
        return f;
    endfunction

    task automatic directed();
        localparam int MX = 32'h7fffffff;
        localparam int MN = 32'h80000000;
        send_facet(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_facet(mk(1, 0, 0, -1, 0, 0, 0, 1, 0, 1));
        send_facet(mk(1, 0, 0, 0, 1, 0, 0, 0, 1, 1));
        send_facet(mk(1, 0, 0, 0, 0, 1, 0, 1, 0, 1));
        send_facet(mk(1, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_facet(mk(1, 0, 0, 0, 0, 1, 0, 1, 0, 1));
        send_facet(mk(-4, -4, 1, 4, -4, 1, 0, 5, 1, 1));
        send_facet(mk(-4, -4, -1, 0, 5, -1, 4, -4, -1, 1));
        send_facet(mk(MX, MX, MX, MN, MN, MN, MX, MN, MX, 1));
        send_facet(mk(MN, 0, 0, 0, MN, 0, 0, 0, MN, 1));
        send_facet(mk(MX, 0, 0, 0, MX, 0, 0, 0, MX, 1));
        send_facet(mk(MX, 1, 0, MN, 0, 1, 1, MX, MN, 0));
        send_facet(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0));
        send_facet(mk(3, 1, 2, 2, 3, 1, 1, 2, 3, 1));
        send_facet(mk(-65536, 0, 65536, 65536, -65536, 0, 0, 65536, -65536, 1));
        send_facet(mk(7, 0, 0, 0, 7, 0, -7, -7, 0, 1));
    endtask

    initial begin
        i_out_stall <= 1'b1;
        @(posedge i_rst_n);
        forever begin
            int g;
            g = pick_gap();
            if (g > 0) begin
                i_out_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_winding_number, o_saturated);
        end
    end

    initial begin
        sb = new();
        no_gaps = 0;
        cur_q[0] = 0; cur_q[1] = 0; cur_q[2] = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} <= '0;
        i_last_triangle <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();
        run_sets(RANDOM_ITEMS / NUM_PHASES);
        set_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        run_sets(RANDOM_ITEMS / NUM_PHASES);
        set_query(32'h80000000, 32'h80000000, 32'h80000000);
        run_sets(RANDOM_ITEMS / NUM_PHASES);
        set_query(32'h80000000, 32'h7fffffff, 32'h0);
        run_sets(RANDOM_ITEMS / NUM_PHASES);
        for (int p = 0; p < 2; p++) begin
            set_query($urandom, $urandom, $urandom);
            run_sets(RANDOM_ITEMS / NUM_PHASES);
        end
        wait_idle();

        $display("covered %0d triangles in %0d sets over %0d query points",
                 sb.facets_seen, sb.sets_seen, NUM_PHASES);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// ===== triangle_solid_angle_winding_sum_core.f =====
rtl/trisa_pkg.sv
rtl/trisa_isqrt.sv
rtl/trisa_cordic.sv
rtl/triangle_solid_angle_winding_sum_core.sv
sim/testbench.sv
